// ===== sv/rhc_pkg.sv =====
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int PIX_W = 8;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [2*PIX_W-1:0] wide_t;
  typedef logic [2:0]         sector_t;

  localparam pix_t HUE_SECTOR = 8'd43;
  localparam pix_t HUE_GREEN  = 8'd85;
  localparam pix_t HUE_BLUE   = 8'd171;
  localparam pix_t FULL_SCALE = 8'd255;
  localparam int   SECTOR_STEP = 6;
  localparam int   SECTOR_CNT  = 6;

  // restoring divider: DIV_STAGES * DIV_STEPS quotient bits
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = PIX_W / DIV_STAGES;

  typedef enum logic {
    REQ_HSV2RGB = 1'b0,
    REQ_RGB2HSV = 1'b1
  } req_t;

  // first-stage classification of one pixel
  typedef struct packed {
    req_t    req;
    sector_t sector;
    pix_t    frac;
    pix_t    sat;
    pix_t    val;
    pix_t    mx;
    pix_t    span;
    pix_t    adiff;
    logic    neg;
    pix_t    base;
    logic    zero;
  } front_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

endpackage

// ===== sv/rhc_if.sv =====
`timescale 1ns / 1ps

interface rhc_in_if;
  import rhc_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  pix_t chan_a;
  pix_t chan_b;
  pix_t chan_c;

  modport source (output valid, req_type, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, req_type, chan_a, chan_b, chan_c, output ready);
endinterface

interface rhc_out_if;
  import rhc_pkg::*;

  logic valid;
  logic ready;
  pix_t out_a;
  pix_t out_b;
  pix_t out_c;

  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink   (input valid, out_a, out_b, out_c, output ready);
endinterface

// ===== sv/rgb_hsv_convert_8bit.sv =====
`timescale 1ns / 1ps

// 8-bit integer RGB <-> HSV pixel converter. Each input beat carries a
// direction bit (req_type: 0 = HSV to RGB, 1 = RGB to HSV) and three 8-bit
// channels; exactly one converted pixel leaves per input beat, in order.
// Throughput is one beat per clock while the output is not stalled. The path
// holds seven register stages: front, dividend setup, four divider stages
// and the output register, in that order. The depth is set by the two
// 16-by-8 restoring dividers (saturation = 255*span/max, hue offset =
// 43*|diff|/span), which resolve two quotient bits per stage over four
// stages; the HSV-to-RGB products run alongside in three stages and wait in
// a short delay line. The pipeline stalls as a whole: px_in.ready is high
// whenever the output register is empty or its beat is being taken.
// Hue is truncated toward zero and wraps mod 256; grey and black pixels
// give hue and saturation zero.

module rgb_hsv_convert_8bit (
  input logic clk,
  input logic rst,
  rhc_in_if.sink    px_in,
  rhc_out_if.source px_out
);
  import rhc_pkg::*;

  // S1 front, S2 numerators, S3..S6 divider, then output register
  localparam int PIPE = DIV_STAGES + 2;

  typedef struct packed {
    req_t req;
    logic zero;
    logic neg;
    pix_t base;
    pix_t mx;
  } side_t;

  logic   adv;
  logic [PIPE-1:0] vld;
  logic   out_vld;

  front_t front;
  wide_t  num_s, num_h;
  pix_t   den_s, den_h;
  pix_t   quo_s, quo_h;
  side_t  side [DIV_STAGES+1];
  rgb_t   rgb_hsv;
  rgb_t   rgb_dly [2];
  pix_t   res_a, res_b, res_c;
  pix_t   hue;
  side_t  last;

  // global stall: move when the output slot is free or drains this cycle
  assign adv         = !out_vld || px_out.ready;
  assign px_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[PIPE-2:0], px_in.valid};
      out_vld <= vld[PIPE-1];
    end
  end

  rhc_front u_front (
    .clk      (clk),
    .en       (adv),
    .req_type (px_in.req_type),
    .chan_a   (px_in.chan_a),
    .chan_b   (px_in.chan_b),
    .chan_c   (px_in.chan_c),
    .front    (front)
  );

  // S2: dividend setup, 255*span and 43*|diff|
  always_ff @(posedge clk) begin
    if (adv) begin
      num_s   <= {front.span, {PIX_W{1'b0}}} - wide_t'(front.span);
      num_h   <= wide_t'(front.adiff) * wide_t'(HUE_SECTOR);
      den_s   <= front.mx;
      den_h   <= front.span;
      side[0] <= '{req: front.req, zero: front.zero, neg: front.neg,
                   base: front.base, mx: front.mx};
      for (int i = 1; i <= DIV_STAGES; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // zero span means zero divisor; quotient is discarded then
  rhc_div u_div_sat (
    .clk (clk),
    .en  (adv),
    .num (num_s),
    .den (den_s),
    .quo (quo_s)
  );

  rhc_div u_div_hue (
    .clk (clk),
    .en  (adv),
    .num (num_h),
    .den (den_h),
    .quo (quo_h)
  );

  rhc_hsv u_hsv (
    .clk   (clk),
    .en    (adv),
    .front (front),
    .rgb   (rgb_hsv)
  );

  // HSV-to-RGB result ready at S4, hold two more stages to meet the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_dly[0] <= rgb_hsv;
      rgb_dly[1] <= rgb_dly[0];
    end
  end

  assign last = side[DIV_STAGES];
  assign hue  = last.neg ? (last.base - quo_h) : (last.base + quo_h);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last.req == REQ_HSV2RGB) begin
        res_a <= rgb_dly[1].r;
        res_b <= rgb_dly[1].g;
        res_c <= rgb_dly[1].b;
      end else begin
        res_a <= last.zero ? '0 : hue;
        res_b <= last.zero ? '0 : quo_s;
        res_c <= last.mx;
      end
    end
  end

  assign px_out.valid = out_vld;
  assign px_out.out_a = res_a;
  assign px_out.out_b = res_b;
  assign px_out.out_c = res_c;

endmodule

// ===== sv/rhc_front.sv =====
`timescale 1ns / 1ps

module rhc_front (
  input  logic            clk,
  input  logic            en,
  input  logic            req_type,
  input  rhc_pkg::pix_t   chan_a,
  input  rhc_pkg::pix_t   chan_b,
  input  rhc_pkg::pix_t   chan_c,
  output rhc_pkg::front_t front
);
  import rhc_pkg::*;

  front_t front_next;

  always_comb begin
    pix_t             rem;
    pix_t             mn;
    logic signed [8:0] diff;

    front_next     = '0;
    front_next.req = req_t'(req_type);

    // hue sector: largest k with hue >= k*43
    front_next.sector = '0;
    rem               = chan_a;
    for (int k = 1; k < SECTOR_CNT; k++) begin
      if ({1'b0, chan_a} >= 9'(k * HUE_SECTOR)) begin
        front_next.sector = sector_t'(k);
        rem               = chan_a - PIX_W'(k * HUE_SECTOR);
      end
    end
    front_next.frac = PIX_W'(int'(rem) * SECTOR_STEP);
    front_next.sat  = chan_b;
    front_next.val  = chan_c;

    // channel extremes
    front_next.mx = chan_a;
    mn            = chan_a;
    if (chan_b > front_next.mx) front_next.mx = chan_b;
    if (chan_c > front_next.mx) front_next.mx = chan_c;
    if (chan_b < mn) mn = chan_b;
    if (chan_c < mn) mn = chan_c;
    front_next.span = front_next.mx - mn;
    front_next.zero = (front_next.span == '0);

    // red wins ties, then green
    if (front_next.mx == chan_a) begin
      diff            = $signed({1'b0, chan_b}) - $signed({1'b0, chan_c});
      front_next.base = '0;
    end else if (front_next.mx == chan_b) begin
      diff            = $signed({1'b0, chan_c}) - $signed({1'b0, chan_a});
      front_next.base = HUE_GREEN;
    end else begin
      diff            = $signed({1'b0, chan_a}) - $signed({1'b0, chan_b});
      front_next.base = HUE_BLUE;
    end
    front_next.neg   = diff[8];
    front_next.adiff = diff[8] ? PIX_W'(-diff) : diff[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

// ===== sv/rhc_div.sv =====
`timescale 1ns / 1ps

module rhc_div (
  input  logic           clk,
  input  logic           en,
  input  rhc_pkg::wide_t num,
  input  rhc_pkg::pix_t  den,
  output rhc_pkg::pix_t  quo
);
  import rhc_pkg::*;

  // caller guarantees num[15:8] < den, so the quotient fits PIX_W bits
  typedef struct packed {
    pix_t rem;
    pix_t low;
    pix_t quo;
    pix_t den;
  } dstage_t;

  dstage_t st      [DIV_STAGES];
  dstage_t st_next [DIV_STAGES];

  always_comb begin
    dstage_t    cur;
    logic [8:0] trial;

    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        cur = '{rem: num[2*PIX_W-1:PIX_W], low: num[PIX_W-1:0], quo: '0, den: den};
      end else begin
        cur = st[i-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {cur.rem, cur.low[PIX_W-1]};
        cur.low = {cur.low[PIX_W-2:0], 1'b0};
        if (trial >= {1'b0, cur.den}) begin
          cur.rem = PIX_W'(trial - {1'b0, cur.den});
          cur.quo = {cur.quo[PIX_W-2:0], 1'b1};
        end else begin
          cur.rem = trial[PIX_W-1:0];
          cur.quo = {cur.quo[PIX_W-2:0], 1'b0};
        end
      end
      st_next[i] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign quo = st[DIV_STAGES-1].quo;

endmodule

// ===== sv/rhc_hsv.sv =====
`timescale 1ns / 1ps

module rhc_hsv (
  input  logic            clk,
  input  logic            en,
  input  rhc_pkg::front_t front,
  output rhc_pkg::rgb_t   rgb
);
  import rhc_pkg::*;

  // stage 1: p and the scaled fractions
  pix_t    p1, sf1, sfc1, v1;
  sector_t sec1;
  logic    grey1;
  // stage 2: q and t
  pix_t    p2, q2, t2, v2;
  sector_t sec2;
  logic    grey2;
  wide_t   prod_p, prod_sf, prod_sfc, prod_q, prod_t;
  rgb_t    rgb_next;

  assign prod_p   = wide_t'(front.val) * wide_t'(FULL_SCALE - front.sat);
  assign prod_sf  = wide_t'(front.sat) * wide_t'(front.frac);
  assign prod_sfc = wide_t'(front.sat) * wide_t'(FULL_SCALE - front.frac);

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= prod_p[2*PIX_W-1:PIX_W];
      sf1   <= prod_sf[2*PIX_W-1:PIX_W];
      sfc1  <= prod_sfc[2*PIX_W-1:PIX_W];
      v1    <= front.val;
      sec1  <= front.sector;
      grey1 <= (front.sat == '0);
    end
  end

  assign prod_q = wide_t'(v1) * wide_t'(FULL_SCALE - sf1);
  assign prod_t = wide_t'(v1) * wide_t'(FULL_SCALE - sfc1);

  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= p1;
      q2    <= prod_q[2*PIX_W-1:PIX_W];
      t2    <= prod_t[2*PIX_W-1:PIX_W];
      v2    <= v1;
      sec2  <= sec1;
      grey2 <= grey1;
    end
  end

  always_comb begin
    case (sec2)
      3'd0:    rgb_next = '{r: v2, g: t2, b: p2};
      3'd1:    rgb_next = '{r: q2, g: v2, b: p2};
      3'd2:    rgb_next = '{r: p2, g: v2, b: t2};
      3'd3:    rgb_next = '{r: p2, g: q2, b: v2};
      3'd4:    rgb_next = '{r: t2, g: p2, b: v2};
      default: rgb_next = '{r: v2, g: p2, b: q2};
    endcase
    if (grey2) begin
      rgb_next = '{r: v2, g: v2, b: v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb <= rgb_next;
    end
  end

endmodule

// ===== bench/rgb_hsv_convert_8bit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the RGB <-> HSV pixel converter.
// Flow: a short table of hand-picked pixels, then random pixels. Every accepted
// input beat queues the converted pixel predicted here. Every output beat is
// checked against the head of that queue. Both handshakes idle at random, with
// occasional back-to-back stretches on either side.
module rgb_hsv_convert_8bit_tb;
  import rhc_pkg::*;

  // Conversion constants as signed ints. The package ones are 8-bit unsigned,
  // and mixing them in would make the signed hue math unsigned.
  localparam int SECTOR_W   = 43;
  localparam int BASE_GREEN = 85;
  localparam int BASE_BLUE  = 171;
  localparam int SCALE      = 255;
  localparam int FRAC_MUL   = 6;

  localparam int TABLE_N      = 25;
  localparam int RANDOM_N     = 1800;
  localparam int MAX_IDLE     = 18;
  localparam int MODE_SPAN    = 32;   // beats between redraws of the burst mode
  localparam int DRAIN_CYCLES = 20;   // pipeline is 7 deep, leave some slack
  localparam int REPORT_MAX   = 10;

  localparam bit TYPED   = 1'b1;    // row carries its own answer
  localparam bit PREDICT = 1'b0;    // row is checked against the predictor

  typedef struct packed {
    pix_t a;
    pix_t b;
    pix_t c;
  } trio_t;

  typedef struct {
    req_t  req;
    pix_t  a;
    pix_t  b;
    pix_t  c;
    bit    typed;
    trio_t want;
  } pixel_row_t;

  typedef struct {
    int    id;
    trio_t px;
  } pending_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhc_in_if  pix_in ();
  rhc_out_if pix_out ();

  rgb_hsv_convert_8bit dut (
    .clk    (clk),
    .rst    (rst),
    .px_in  (pix_in),
    .px_out (pix_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pending_px_t pending_px[$];
  int          mismatches = 0;
  int          sent_px    = 0;

  // Hand-picked pixels. Typed answers only where obvious: grey, black,
  // primaries. Sector edges, ties and negative hue offsets go to the predictor.
  pixel_row_t pixel_table [TABLE_N] = '{
    // zero saturation: grey at the value
    '{REQ_HSV2RGB, 8'd0,   8'd0,   8'd0,   TYPED,   '{8'd0,   8'd0,   8'd0}},
    '{REQ_HSV2RGB, 8'd255, 8'd0,   8'd255, TYPED,   '{8'd255, 8'd255, 8'd255}},
    '{REQ_HSV2RGB, 8'd128, 8'd0,   8'd77,  TYPED,   '{8'd77,  8'd77,  8'd77}},
    // each hue sector, both edges of sector zero, and the narrow last sector
    '{REQ_HSV2RGB, 8'd0,   8'd255, 8'd255, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd42,  8'd255, 8'd255, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd43,  8'd200, 8'd200, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd86,  8'd180, 8'd240, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd129, 8'd90,  8'd130, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd172, 8'd255, 8'd128, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd215, 8'd150, 8'd255, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd255, 8'd255, 8'd255, PREDICT, '0},
    '{REQ_HSV2RGB, 8'd255, 8'd1,   8'd1,   PREDICT, '0},
    // black, then grey: hue and saturation zero
    '{REQ_RGB2HSV, 8'd0,   8'd0,   8'd0,   TYPED,   '{8'd0,   8'd0,   8'd0}},
    '{REQ_RGB2HSV, 8'd255, 8'd255, 8'd255, TYPED,   '{8'd0,   8'd0,   8'd255}},
    '{REQ_RGB2HSV, 8'd90,  8'd90,  8'd90,  TYPED,   '{8'd0,   8'd0,   8'd90}},
    // primaries land on the sector bases
    '{REQ_RGB2HSV, 8'd255, 8'd0,   8'd0,   TYPED,   '{8'd0,   8'd255, 8'd255}},
    '{REQ_RGB2HSV, 8'd0,   8'd255, 8'd0,   TYPED,   '{8'd85,  8'd255, 8'd255}},
    '{REQ_RGB2HSV, 8'd0,   8'd0,   8'd255, TYPED,   '{8'd171, 8'd255, 8'd255}},
    // red/blue tie with a negative offset, then a plain negative wrap
    '{REQ_RGB2HSV, 8'd255, 8'd0,   8'd255, PREDICT, '0},
    '{REQ_RGB2HSV, 8'd200, 8'd10,  8'd100, PREDICT, '0},
    // red/green tie, then green/blue tie
    '{REQ_RGB2HSV, 8'd255, 8'd255, 8'd0,   PREDICT, '0},
    '{REQ_RGB2HSV, 8'd0,   8'd255, 8'd255, PREDICT, '0},
    // tiny value, tiny saturation, and a general pixel
    '{REQ_RGB2HSV, 8'd1,   8'd0,   8'd0,   PREDICT, '0},
    '{REQ_RGB2HSV, 8'd255, 8'd254, 8'd254, PREDICT, '0},
    '{REQ_RGB2HSV, 8'd100, 8'd255, 8'd200, PREDICT, '0}
  };

  // Predicted output pixel for one input beat.
  function automatic trio_t convert_pixel(req_t req, pix_t a, pix_t b, pix_t c);
    int    h, s, v, sec, frac, p, q, t;
    int    r, g, bl, mx, mn, span, hue;
    trio_t res;
    res = '0;
    if (req == REQ_HSV2RGB) begin
      h = a;
      s = b;
      v = c;
      if (s == 0) begin
        res.a = c;
        res.b = c;
        res.c = c;
      end else begin
        sec  = h / SECTOR_W;
        frac = ((h - sec * SECTOR_W) * FRAC_MUL) & 255;
        p = ((v * (SCALE - s)) >> 8) & 255;
        q = ((v * (SCALE - ((s * frac) >> 8))) >> 8) & 255;
        t = ((v * (SCALE - ((s * (SCALE - frac)) >> 8))) >> 8) & 255;
        case (sec)
          0: begin res.a = pix_t'(v); res.b = pix_t'(t); res.c = pix_t'(p); end
          1: begin res.a = pix_t'(q); res.b = pix_t'(v); res.c = pix_t'(p); end
          2: begin res.a = pix_t'(p); res.b = pix_t'(v); res.c = pix_t'(t); end
          3: begin res.a = pix_t'(p); res.b = pix_t'(q); res.c = pix_t'(v); end
          4: begin res.a = pix_t'(t); res.b = pix_t'(p); res.c = pix_t'(v); end
          default: begin res.a = pix_t'(v); res.b = pix_t'(p); res.c = pix_t'(q); end
        endcase
      end
    end else begin
      r  = a;
      g  = b;
      bl = c;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (bl > mx) mx = bl;
      if (g < mn) mn = g;
      if (bl < mn) mn = bl;
      res.c = pix_t'(mx);
      span  = mx - mn;
      if (mx != 0 && span != 0) begin
        s = (SCALE * span) / mx;
        res.b = pix_t'(s);
        // ties: red wins over green, green over blue; division truncates to 0
        if (mx == r)      hue = (SECTOR_W * (g - bl)) / span;
        else if (mx == g) hue = BASE_GREEN + (SECTOR_W * (bl - r)) / span;
        else              hue = BASE_BLUE + (SECTOR_W * (r - g)) / span;
        res.a = pix_t'(hue);   // low byte: negative offsets wrap mod 256
      end
    end
    return res;
  endfunction

  // Channel value skewed toward the ends of the range.
  function automatic pix_t pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return pix_t'($urandom_range(0, 3));
      3: return pix_t'($urandom_range(252, 255));
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Hold one pixel on the input until it is taken, then queue its answer.
  task automatic offer_pixel(req_t req, pix_t a, pix_t b, pix_t c, bit typed,
                             trio_t want);
    pending_px_t entry;
    pix_in.valid    <= 1'b1;
    pix_in.req_type <= req;
    pix_in.chan_a   <= a;
    pix_in.chan_b   <= b;
    pix_in.chan_c   <= c;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    entry.id = sent_px;
    entry.px = typed ? want : convert_pixel(req, a, b, c);
    pending_px.push_back(entry);
    sent_px++;
  endtask

  // Input-side gap after a beat. valid only drops when a gap follows, so a
  // back-to-back beat never sees a low and a high land in the same step.
  task automatic input_gap(bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Source: reset, table, random pixels, then drain and verdict.
  initial begin
    bit    burst;
    req_t  req;
    pix_t  a, b, c;
    pix_in.valid    = 1'b0;
    pix_in.req_type = REQ_HSV2RGB;
    pix_in.chan_a   = '0;
    pix_in.chan_b   = '0;
    pix_in.chan_c   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst = 1'b0;
    for (int i = 0; i < TABLE_N; i++) begin
      offer_pixel(pixel_table[i].req, pixel_table[i].a, pixel_table[i].b,
                  pixel_table[i].c, pixel_table[i].typed, pixel_table[i].want);
      input_gap(i >= TABLE_N / 2);   // second half back to back
    end

    for (int i = 0; i < RANDOM_N; i++) begin
      if (i % MODE_SPAN == 0) burst = ($urandom_range(0, 3) == 0);
      req = $urandom_range(0, 1) ? REQ_RGB2HSV : REQ_HSV2RGB;
      a = pick_channel();
      b = pick_channel();
      c = pick_channel();
      // force channel ties: grey pixels, max ties, zero saturation paths
      case ($urandom_range(0, 7))
        0: b = a;
        1: c = a;
        2: c = b;
        3: begin b = a; c = a; end
        default: ;
      endcase
      offer_pixel(req, a, b, c, PREDICT, '0);
      if (i == RANDOM_N - 1) pix_in.valid <= 1'b0;
      else input_gap(burst);
    end

    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_px.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Sink: random back-pressure, check every output beat in order.
  initial begin
    int          stall;
    int          beats;
    bit          burst;
    pending_px_t head;
    trio_t       got;
    pix_out.ready = 1'b0;
    beats = 0;
    burst = 1'b0;
    @(negedge rst);
    forever begin
      if (beats % MODE_SPAN == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk);
      while (!pix_out.valid) @(posedge clk);
      beats++;
      got.a = pix_out.out_a;
      got.b = pix_out.out_b;
      got.c = pix_out.out_c;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output beat %0d: %0d %0d %0d", beats, got.a, got.b,
                   got.c);
      end else begin
        head = pending_px.pop_front();
        if (got.a !== head.px.a || got.b !== head.px.b || got.c !== head.px.c) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pixel %0d: want a=%0d b=%0d c=%0d got a=%0d b=%0d c=%0d",
                     head.id, head.px.a, head.px.b, head.px.c, got.a, got.b, got.c);
        end
      end
    end
  end

  // Watchdog: slowest legal run is well under half a millisecond.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
